// ----- rtl/emc_pkg.sv -----
// Shared types, widths and constants for the millisecond-to-calendar converter.
// No dependencies; emc_front, emc_back and the top level import this package.
package emc_pkg;

  // Parameter defaults
  localparam int EPOCH_YEAR_DEF       = 2000;
  localparam int SPAN_YEARS_DEF       = 64;
  localparam int EPOCH_DAY_OFFSET_DEF = 10957;

  // Field widths
  localparam int MILLIS_W = 47;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int MDAY_W   = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MSEC_W   = 10;

  // Internal widths
  localparam int DAY_W    = 21;  // whole days since 1970 for any 47-bit count
  localparam int DAYPOS_W = 17;  // day position from the leap-aligned base year
  localparam int DOY_W    = 9;   // day of year, 0..365

  // Odd factors of the time divisors: 1000 = 8*125, 86400 = 128*675,
  // 3600 = 16*225, 60 = 4*15
  localparam int DIV_MSEC   = 125;
  localparam int DIV_DAY    = 675;
  localparam int DIV_HOUR   = 225;
  localparam int DIV_MINUTE = 15;

  localparam int DAYS_CYCLE  = 1461;  // four years, first one leap
  localparam int DAYS_LEAP   = 366;
  localparam int DAYS_COMMON = 365;

  localparam int QUEUE_DEPTH = 4;

  localparam int MONTHS = 12;

  // First day of each month, zero-based day of year
  localparam logic [DOY_W-1:0] MONTH_START_COMMON [MONTHS] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  localparam logic [DOY_W-1:0] MONTH_START_LEAP [MONTHS] =
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

  // Beat moved from the front end through the queue to the back end
  typedef struct packed {
    logic                oor;
    logic [DAYPOS_W-1:0] day_pos;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MSEC_W-1:0]   millisecond;
  } item_t;

  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
    month_start = leap ? MONTH_START_LEAP[m] : MONTH_START_COMMON[m];
  endfunction

endpackage

// ----- rtl/emc_cdiv.sv -----
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// No package dependency; instantiated by emc_front and emc_back.
module emc_cdiv #(
  parameter int XW  = 16,
  parameter int QW  = 8,
  parameter int DIV = 10,
  parameter int SW  = 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [XW-1:0]           x_i,
  input  logic [SW-1:0]           side_i,
  output logic [QW-1:0]           q_o,
  output logic [$clog2(DIV)-1:0]  r_o,
  output logic [SW-1:0]           side_o
);

  localparam int RW = $clog2(DIV);
  localparam longint unsigned Recip = (64'd1 << XW) / DIV;

  logic [XW+QW-1:0] prod;
  logic [XW-1:0]    x_q;
  logic [QW-1:0]    qe_q;
  logic [SW-1:0]    side_q;
  logic [RW:0]      rem_full;
  logic [QW-1:0]    q_q;
  logic [RW-1:0]    r_q;
  logic [SW-1:0]    side2_q;

  // Estimate is the true quotient or one below it
  assign prod = (XW+QW)'(x_i) * (XW+QW)'(QW'(Recip));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_i;
      qe_q   <= prod[XW+QW-1:XW];
      side_q <= side_i;
    end
  end

  assign rem_full = (RW+1)'(x_q - XW'(qe_q) * XW'(DIV));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side_q;
      if (rem_full >= (RW+1)'(DIV)) begin
        q_q <= qe_q + QW'(1);
        r_q <= RW'(rem_full - (RW+1)'(DIV));
      end else begin
        q_q <= qe_q;
        r_q <= RW'(rem_full);
      end
    end
  end

  assign q_o    = q_q;
  assign r_o    = r_q;
  assign side_o = side2_q;

endmodule

// ----- rtl/emc_front.sv -----
// Front end: accept a millisecond count, split it into days and time of day,
// classify the day against the span. Depends on emc_pkg and emc_cdiv.
module emc_front #(
  parameter int EPOCH_YEAR       = emc_pkg::EPOCH_YEAR_DEF,
  parameter int SPAN_YEARS       = emc_pkg::SPAN_YEARS_DEF,
  parameter int EPOCH_DAY_OFFSET = emc_pkg::EPOCH_DAY_OFFSET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [emc_pkg::MILLIS_W-1:0] epoch_millis_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output emc_pkg::item_t               item_o
);
  import emc_pkg::*;

  localparam int Stages    = 11;
  localparam int Phase     = EPOCH_YEAR % 4;
  localparam int PreDays   = DAYS_COMMON * Phase + ((Phase > 0) ? 1 : 0);
  localparam int BaseSpan  = Phase + SPAN_YEARS;
  localparam int SpanDays  = DAYS_COMMON * BaseSpan + (BaseSpan + 3) / 4 - PreDays;

  logic [Stages-1:0] vld_q;
  logic              adv;

  // Whole chain moves together; hold only when the last stage cannot drain
  assign adv          = !vld_q[Stages-1] || item_ready_i;
  assign in_ready_o   = adv;
  assign item_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // Milliseconds: t/1000 = (t>>3)/125, high half of t>>3 first
  logic [15:0] qa;
  logic [6:0]  ra;
  logic [24:0] sa;

  emc_cdiv #(.XW(22), .QW(16), .DIV(DIV_MSEC), .SW(25)) u_div_ms_hi (
    .clk_i, .en_i(adv), .x_i(epoch_millis_i[46:25]), .side_i(epoch_millis_i[24:0]),
    .q_o(qa), .r_o(ra), .side_o(sa)
  );

  logic [22:0] qb;
  logic [6:0]  rb;
  logic [18:0] sb;

  emc_cdiv #(.XW(29), .QW(23), .DIV(DIV_MSEC), .SW(19)) u_div_ms_lo (
    .clk_i, .en_i(adv), .x_i({ra, sa[24:3]}), .side_i({qa, sa[2:0]}),
    .q_o(qb), .r_o(rb), .side_o(sb)
  );

  logic [37:0]       secs;
  logic [MSEC_W-1:0] ms_b;

  assign secs = {sb[18:3], qb[21:0]};
  assign ms_b = {rb, sb[2:0]};

  // Days: secs/86400 = (secs>>7)/675
  logic [21:0] qc;
  logic [9:0]  rc;
  logic [16:0] sc;

  emc_cdiv #(.XW(31), .QW(22), .DIV(DIV_DAY), .SW(17)) u_div_day (
    .clk_i, .en_i(adv), .x_i(secs[37:7]), .side_i({secs[6:0], ms_b}),
    .q_o(qc), .r_o(rc), .side_o(sc)
  );

  logic [DAY_W-1:0]    day;
  logic [DAY_W-1:0]    day_rel;
  logic                oor_d;
  logic [DAYPOS_W-1:0] dpos_d;
  logic                oor_q;
  logic [DAYPOS_W-1:0] dpos_q;
  logic [16:0]         sod_q;
  logic [MSEC_W-1:0]   ms_q;

  assign day     = qc[DAY_W-1:0];
  assign day_rel = day - DAY_W'(EPOCH_DAY_OFFSET);
  assign oor_d   = (day < DAY_W'(EPOCH_DAY_OFFSET)) || (day_rel >= DAY_W'(SpanDays));
  assign dpos_d  = day_rel[DAYPOS_W-1:0] + DAYPOS_W'(PreDays);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor_q  <= oor_d;
      dpos_q <= dpos_d;
      sod_q  <= {rc, sc[16:10]};
      ms_q   <= sc[9:0];
    end
  end

  // Hour: sod/3600 = (sod>>4)/225
  logic [5:0]  qd;
  logic [7:0]  rd;
  logic [31:0] sd;

  emc_cdiv #(.XW(13), .QW(6), .DIV(DIV_HOUR), .SW(32)) u_div_hour (
    .clk_i, .en_i(adv), .x_i(sod_q[16:4]), .side_i({oor_q, dpos_q, sod_q[3:0], ms_q}),
    .q_o(qd), .r_o(rd), .side_o(sd)
  );

  logic [11:0] r3600;
  assign r3600 = {rd, sd[13:10]};

  // Minute and second: r/60 = (r>>2)/15
  logic [6:0]  qe;
  logic [3:0]  re;
  logic [34:0] se;

  emc_cdiv #(.XW(10), .QW(7), .DIV(DIV_MINUTE), .SW(35)) u_div_min (
    .clk_i, .en_i(adv), .x_i(r3600[11:2]),
    .side_i({sd[31], sd[30:14], qd[HOUR_W-1:0], r3600[1:0], sd[9:0]}),
    .q_o(qe), .r_o(re), .side_o(se)
  );

  assign item_o.oor         = se[34];
  assign item_o.day_pos     = se[33:17];
  assign item_o.hour        = se[16:12];
  assign item_o.minute      = qe[MINUTE_W-1:0];
  assign item_o.second      = {re, se[11:10]};
  assign item_o.millisecond = se[9:0];

endmodule

// ----- rtl/emc_fifo.sv -----
// Short register queue that parts the front end from the back end.
// No package dependency.
module emc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from an empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/emc_back.sv -----
// Back end: turn the day position into year, month and day, register the result.
// Depends on emc_pkg and emc_cdiv.
module emc_back #(
  parameter int EPOCH_YEAR = emc_pkg::EPOCH_YEAR_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  emc_pkg::item_t               item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_of_range_o,
  output logic [emc_pkg::YEAR_W-1:0]   year_o,
  output logic [emc_pkg::MONTH_W-1:0]  month_o,
  output logic [emc_pkg::MDAY_W-1:0]   day_of_month_o,
  output logic [emc_pkg::HOUR_W-1:0]   hour_o,
  output logic [emc_pkg::MINUTE_W-1:0] minute_o,
  output logic [emc_pkg::SECOND_W-1:0] second_o,
  output logic [emc_pkg::MSEC_W-1:0]   millisecond_o
);
  import emc_pkg::*;

  localparam int BaseYear = EPOCH_YEAR - EPOCH_YEAR % 4;
  localparam int TimeW    = HOUR_W + MINUTE_W + SECOND_W + MSEC_W;

  logic [2:0] vb_q;
  logic       out_valid_q;
  logic       adv;

  assign adv          = !out_valid_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vb_q        <= {vb_q[1:0], item_valid_i};
      out_valid_q <= vb_q[2];
    end
  end

  // Four-year cycles from the leap-aligned base year
  logic [6:0]       cyc;
  logic [10:0]      rcy;
  logic [TimeW:0]   sf;

  emc_cdiv #(.XW(DAYPOS_W), .QW(7), .DIV(DAYS_CYCLE), .SW(TimeW + 1)) u_div_cycle (
    .clk_i, .en_i(adv), .x_i(item_i.day_pos),
    .side_i({item_i.oor, item_i.hour, item_i.minute, item_i.second, item_i.millisecond}),
    .q_o(cyc), .r_o(rcy), .side_o(sf)
  );

  logic [1:0]        yi;
  logic [DOY_W-1:0]  doy_d;
  logic [YEAR_W-1:0] year_d;
  logic              leap_d;
  logic              oor_q;
  logic [YEAR_W-1:0] year_q;
  logic [DOY_W-1:0]  doy_q;
  logic              leap_q;
  logic [TimeW-1:0]  time_q;

  // Pick the year inside the cycle; out of range falls back to the first day
  always_comb begin
    if (rcy < 11'(DAYS_LEAP)) begin
      yi    = 2'd0;
      doy_d = DOY_W'(rcy);
    end else if (rcy < 11'(DAYS_LEAP + DAYS_COMMON)) begin
      yi    = 2'd1;
      doy_d = DOY_W'(rcy - 11'(DAYS_LEAP));
    end else if (rcy < 11'(DAYS_LEAP + 2 * DAYS_COMMON)) begin
      yi    = 2'd2;
      doy_d = DOY_W'(rcy - 11'(DAYS_LEAP + DAYS_COMMON));
    end else begin
      yi    = 2'd3;
      doy_d = DOY_W'(rcy - 11'(DAYS_LEAP + 2 * DAYS_COMMON));
    end
    leap_d = (yi == 2'd0);
    year_d = YEAR_W'(BaseYear) + YEAR_W'({cyc, 2'b00}) + YEAR_W'(yi);
    if (sf[TimeW]) begin
      year_d = YEAR_W'(EPOCH_YEAR);
      doy_d  = '0;
      leap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oor_q  <= sf[TimeW];
      year_q <= year_d;
      doy_q  <= doy_d;
      leap_q <= leap_d;
      time_q <= sf[TimeW-1:0];
    end
  end

  logic [MONTH_W-1:0] mon;
  logic [MDAY_W-1:0]  mday;

  always_comb begin
    mon = '0;
    for (int k = 1; k < MONTHS; k++) begin
      if (doy_q >= month_start(leap_q, MONTH_W'(k))) begin
        mon = MONTH_W'(k);
      end
    end
    mday = MDAY_W'(doy_q - month_start(leap_q, mon) + DOY_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_of_range_o <= oor_q;
      year_o         <= year_q;
      month_o        <= mon + MONTH_W'(1);
      day_of_month_o <= mday;
      hour_o         <= time_q[TimeW-1 -: HOUR_W];
      minute_o       <= time_q[SECOND_W+MSEC_W +: MINUTE_W];
      second_o       <= time_q[MSEC_W +: SECOND_W];
      millisecond_o  <= time_q[MSEC_W-1:0];
    end
  end

`ifndef SYNTH
  a_oor_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> year_o == YEAR_W'(EPOCH_YEAR) &&
    month_o == MONTH_W'(1) && day_of_month_o == MDAY_W'(1))
    else $error("out-of-range date is not the first epoch day");
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_o >= MONTH_W'(1) && month_o <= MONTH_W'(12))
    else $error("month outside 1..12");
  a_feb_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_o == MONTH_W'(2) |-> day_of_month_o <= MDAY_W'(29) &&
    day_of_month_o >= MDAY_W'(1))
    else $error("February day out of range");
`endif

endmodule

// ----- rtl/epoch_msec_to_calendar.sv -----
// Top level of the millisecond-count to calendar date and time converter.
// Depends on emc_pkg, emc_cdiv, emc_front, emc_fifo and emc_back.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid_i / in_ready_o  | epoch_millis_i
//   out     | out_valid_o/out_ready_i  | out_of_range_o, year_o, month_o,
//           |                        | day_of_month_o, hour_o, minute_o,
//           |                        | second_o, millisecond_o
//
// One beat in per cycle, one beat out per cycle, sustained while the output is not stalled.
// The path holds eleven front stages (five constant dividers of two
// stages each plus the range check), one queue slot, four back stages.
// Reset clears the stage valid bits and the queue pointers and count; nothing else.
// A stall at the output holds the output register and the back stages, the
// four-entry queue fills, and only then does in_ready_o drop.
module epoch_msec_to_calendar #(
  parameter int EPOCH_YEAR       = emc_pkg::EPOCH_YEAR_DEF,
  parameter int SPAN_YEARS       = emc_pkg::SPAN_YEARS_DEF,
  parameter int EPOCH_DAY_OFFSET = emc_pkg::EPOCH_DAY_OFFSET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [emc_pkg::MILLIS_W-1:0] epoch_millis_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_of_range_o,
  output logic [emc_pkg::YEAR_W-1:0]   year_o,
  output logic [emc_pkg::MONTH_W-1:0]  month_o,
  output logic [emc_pkg::MDAY_W-1:0]   day_of_month_o,
  output logic [emc_pkg::HOUR_W-1:0]   hour_o,
  output logic [emc_pkg::MINUTE_W-1:0] minute_o,
  output logic [emc_pkg::SECOND_W-1:0] second_o,
  output logic [emc_pkg::MSEC_W-1:0]   millisecond_o
);
  import emc_pkg::*;

  // Front end to queue
  item_t front_item;
  logic  front_valid;
  logic  q_full;
  logic  q_push;

  // Queue to back end
  item_t back_item;
  logic  q_empty;
  logic  back_ready;
  logic  q_pop;

  emc_front #(
    .EPOCH_YEAR      (EPOCH_YEAR),
    .SPAN_YEARS      (SPAN_YEARS),
    .EPOCH_DAY_OFFSET(EPOCH_DAY_OFFSET)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .epoch_millis_i,
    .item_valid_o(front_valid),
    .item_ready_i(!q_full),
    .item_o      (front_item)
  );

  // Push only what the queue can hold; drain whenever the back end advances
  assign q_push = front_valid && !q_full;
  assign q_pop  = back_ready && !q_empty;

  emc_fifo #(
    .W    ($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (q_push),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (back_item),
    .empty_o(q_empty)
  );

  emc_back #(
    .EPOCH_YEAR(EPOCH_YEAR)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i(!q_empty),
    .item_ready_o(back_ready),
    .item_i      (back_item),
    .out_valid_o,
    .out_ready_i,
    .out_of_range_o,
    .year_o,
    .month_o,
    .day_of_month_o,
    .hour_o,
    .minute_o,
    .second_o,
    .millisecond_o
  );

endmodule
